// ----- hdl/scpr_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the second chance page replacement block
// no dependencies
package scpr_pkg;
  localparam int FRAMES_DEF = 64;
  localparam int OWNERS_DEF = 16;
  localparam int PAGES_PER_OWNER_DEF = 16;

  localparam int CMD_W = 1;
  localparam int OWNER_W = 4;
  localparam int PIDX_W = 4;
  localparam int STATUS_W = 3;
  localparam int FRAME_W = 6;
  localparam int VPAGE_W = 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_FILL     = 3'd1,
    ST_REPLACE  = 3'd2,
    ST_NOVICTIM = 3'd3,
    ST_RELEASED = 3'd4,
    ST_ABSENT   = 3'd5
  } status_t;

  localparam logic CMD_ACCESS  = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,     // read page table for the latched request
    OP_SCAN,     // read owner and page of frame at scan pointer
    OP_PLACE,    // install page into selected frame
    OP_HITREF,   // set reference bit on hit frame
    OP_FREE,     // release frame of page
    OP_PTCLR,    // clear presence of the victim page
    OP_REFCLR    // clear reference bit at scan pointer
  } op_t;

  typedef struct packed {
    op_t  op;
    logic scan_rst;
    logic scan_inc;
  } ctl_t;

  typedef struct packed {
    logic in_range;
    logic is_rel;
    logic present;
    logic fr_valid;
    logic fr_ref;
    logic fr_own_eq;
    logic scan_last;
    logic vp_in_range;
  } sts_t;
endpackage

// ----- hdl/scpr_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interface carrying a generic payload
// depends on nothing
interface scpr_if #(parameter int W = 1) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/second_chance_page_replacement.sv -----
`timescale 1ns / 1ps
// second chance page replacement over a shared pool of physical frames
// input channel: cmd, owner, page_index; result channel: status, frame, victim_page
// one result transaction per input transaction, in order
// hit, fill, release and out of range requests go through the lookup, decode and
// output states before the result is valid
// a fault with no free frame sweeps frames through the scan and evaluate states, up to
// two passes, and evicts the victim it finds before the output state
// one request is in flight at a time; input is taken again once the result
// register is empty or being drained
// synchronous reset empties every frame and marks every page absent
// a stalled result holds its register and stops new input until it is taken
// depends on scpr_pkg, scpr_if, scpr_ctrl, scpr_datapath
module second_chance_page_replacement #(
  parameter int FRAMES = scpr_pkg::FRAMES_DEF,
  parameter int OWNERS = scpr_pkg::OWNERS_DEF,
  parameter int PAGES_PER_OWNER = scpr_pkg::PAGES_PER_OWNER_DEF
) (
  input  logic clk,
  input  logic rst_n,
  scpr_if.sink   in_ch,
  scpr_if.source out_ch
);
  import scpr_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic ld;
  logic [FRAME_W-1:0] res_frame;
  logic [VPAGE_W-1:0] res_vpage;
  logic [STATUS_W-1:0] o_st;
  logic [FRAME_W-1:0] o_fr;
  logic [VPAGE_W-1:0] o_vp;

  // in payload: {cmd, owner, page_index}; out payload: {status, frame, victim_page}
  scpr_ctrl #(.FRAMES(FRAMES)) u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .ld, .ctl, .sts, .res_frame, .res_vpage,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_status(o_st), .out_frame(o_fr), .out_victim_page(o_vp)
  );

  scpr_datapath #(.FRAMES(FRAMES), .OWNERS(OWNERS), .PAGES_PER_OWNER(PAGES_PER_OWNER)) u_dp (
    .clk, .rst_n, .ld,
    .in_cmd(in_ch.data[8]), .in_owner(in_ch.data[7:4]), .in_page_index(in_ch.data[3:0]),
    .ctl, .sts, .res_frame, .res_vpage
  );

  assign out_ch.data = {o_st, o_fr, o_vp};
endmodule

// ----- hdl/scpr_datapath.sv -----
`timescale 1ns / 1ps
// frame table, page table and scan pointer of the replacement block
// depends on scpr_pkg
module scpr_datapath #(
  parameter int FRAMES = 64,
  parameter int OWNERS = 16,
  parameter int PAGES_PER_OWNER = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   ld,
  input  logic                   in_cmd,
  input  logic [scpr_pkg::OWNER_W-1:0] in_owner,
  input  logic [scpr_pkg::PIDX_W-1:0]  in_page_index,
  input  scpr_pkg::ctl_t         ctl,
  output scpr_pkg::sts_t         sts,
  output logic [scpr_pkg::FRAME_W-1:0] res_frame,
  output logic [scpr_pkg::VPAGE_W-1:0] res_vpage
);
  import scpr_pkg::*;

  localparam int NPAGES = OWNERS * PAGES_PER_OWNER;
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int GW = (NPAGES > 1) ? $clog2(NPAGES) : 1;
  localparam int GXW = OWNER_W + PIDX_W + 12;

  // frame table: valid and ref bits in flops, page and owner in memory
  logic [FRAMES-1:0] fvalid_r, fref_r;
  logic [GW-1:0]     fpage_mem [FRAMES];
  logic [OWNER_W-1:0] fown_mem [FRAMES];
  logic [NPAGES-1:0] present_r;
  logic [FW-1:0]     pframe_mem [NPAGES];

  logic              cmd_r;
  logic [OWNER_W-1:0] own_r;
  logic [GW-1:0]     gid_r;
  logic              inr_r;
  logic [FW-1:0]     scan_r;
  logic [FW-1:0]     hitf_r;
  logic [GW-1:0]     vpage_r;
  logic [OWNER_W-1:0] rown_r;
  logic [FW-1:0]     freef;
  logic              anyfree;
  logic [GXW-1:0]    gid_x;

  assign gid_x = GXW'(in_owner) * GXW'(PAGES_PER_OWNER) + GXW'(in_page_index);

  // lowest free frame, priority encoder
  always_comb begin
    freef = '0;
    anyfree = 1'b0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (!fvalid_r[i]) begin
        freef = FW'(i);
        anyfree = 1'b1;
      end
    end
  end

  // request latch and table reads
  always_ff @(posedge clk) begin
    if (ld) begin
      cmd_r <= in_cmd;
      own_r <= in_owner;
      gid_r <= GW'(gid_x);
      inr_r <= (32'(in_owner) < OWNERS) && (32'(in_page_index) < PAGES_PER_OWNER);
    end
    if (ctl.op == OP_LOAD) hitf_r <= pframe_mem[gid_r];
    if (ctl.op == OP_SCAN) begin
      vpage_r <= fpage_mem[scan_r];
      rown_r <= fown_mem[scan_r];
    end
  end

  // scan pointer, starts on the lowest free frame when one exists
  always_ff @(posedge clk) begin
    if (!rst_n) scan_r <= '0;
    else if (ctl.scan_rst) scan_r <= anyfree ? freef : '0;
    else if (ctl.scan_inc) scan_r <= (32'(scan_r) == FRAMES - 1) ? '0 : scan_r + 1'b1;
  end

  // table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvalid_r <= '0;
      fref_r <= '0;
      present_r <= '0;
    end else begin
      case (ctl.op)
        OP_PLACE: begin
          fvalid_r[scan_r] <= 1'b1;
          fref_r[scan_r] <= 1'b1;
          present_r[gid_r] <= 1'b1;
        end
        OP_HITREF: fref_r[hitf_r] <= 1'b1;
        OP_FREE: begin
          fvalid_r[hitf_r] <= 1'b0;
          fref_r[hitf_r] <= 1'b0;
          present_r[gid_r] <= 1'b0;
        end
        OP_REFCLR: fref_r[scan_r] <= 1'b0;
        OP_PTCLR: if (32'(vpage_r) < NPAGES) present_r[vpage_r] <= 1'b0;
        default: ;
      endcase
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (ctl.op == OP_PLACE) begin
      fpage_mem[scan_r] <= gid_r;
      fown_mem[scan_r] <= own_r;
      pframe_mem[gid_r] <= scan_r;
    end
  end

  assign sts.in_range = inr_r;
  assign sts.is_rel = (cmd_r == CMD_RELEASE);
  assign sts.present = present_r[gid_r];
  assign sts.fr_valid = anyfree;
  assign sts.fr_ref = fref_r[scan_r];
  assign sts.fr_own_eq = (rown_r == own_r);
  assign sts.scan_last = (32'(scan_r) == FRAMES - 1);
  assign sts.vp_in_range = 1'b1;

  assign res_frame = FRAME_W'(ctl.op == OP_HITREF || ctl.op == OP_FREE ? hitf_r : scan_r);
  assign res_vpage = VPAGE_W'(vpage_r);
endmodule

// ----- hdl/scpr_ctrl.sv -----
`timescale 1ns / 1ps
// controller sequencing lookup, fill and second chance sweep
// depends on scpr_pkg
module scpr_ctrl #(
  parameter int FRAMES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   ld,
  output scpr_pkg::ctl_t         ctl,
  input  scpr_pkg::sts_t         sts,
  input  logic [scpr_pkg::FRAME_W-1:0] res_frame,
  input  logic [scpr_pkg::VPAGE_W-1:0] res_vpage,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [scpr_pkg::STATUS_W-1:0] out_status,
  output logic [scpr_pkg::FRAME_W-1:0]  out_frame,
  output logic [scpr_pkg::VPAGE_W-1:0]  out_victim_page
);
  import scpr_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_DEC, S_SCAN, S_EVAL, S_EVICT, S_OUT} state_t;

  state_t state_r, state_nxt;
  logic   pass_r, pass_nxt;
  logic   ov_r, ov_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic [FRAME_W-1:0]  fr_r, fr_nxt;
  logic [VPAGE_W-1:0]  vp_r, vp_nxt;

  assign in_ready = (state_r == S_IDLE) && !(ov_r && !out_ready);
  assign ld = in_valid && in_ready;
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_frame = fr_r;
  assign out_victim_page = vp_r;

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    pass_nxt = pass_r;
    ov_nxt = ov_r && !out_ready;
    st_nxt = st_r;
    fr_nxt = fr_r;
    vp_nxt = vp_r;
    ctl = '{op: OP_NONE, scan_rst: 1'b0, scan_inc: 1'b0};
    case (state_r)
      S_IDLE: if (ld) state_nxt = S_LOOK;
      S_LOOK: begin
        ctl.op = OP_LOAD;
        ctl.scan_rst = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        fr_nxt = '0;
        vp_nxt = '0;
        state_nxt = S_OUT;
        pass_nxt = 1'b0;
        if (!sts.in_range) begin
          st_nxt = sts.is_rel ? ST_ABSENT : ST_NOVICTIM;
        end else if (sts.is_rel) begin
          if (sts.present) begin
            ctl.op = OP_FREE;
            st_nxt = ST_RELEASED;
            fr_nxt = res_frame;
          end else st_nxt = ST_ABSENT;
        end else if (sts.present) begin
          ctl.op = OP_HITREF;
          st_nxt = ST_HIT;
          fr_nxt = res_frame;
        end else if (sts.fr_valid) begin
          ctl.op = OP_PLACE;
          st_nxt = ST_FILL;
          fr_nxt = res_frame;
        end else state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // read owner and page of frame at scan pointer
        ctl.op = OP_SCAN;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!sts.fr_own_eq && !sts.fr_ref) state_nxt = S_EVICT;
        else begin
          // a foreign frame with its ref set loses it and is passed over
          if (!sts.fr_own_eq) ctl.op = OP_REFCLR;
          ctl.scan_inc = 1'b1;
          state_nxt = S_SCAN;
          if (sts.scan_last) begin
            if (pass_r) begin
              st_nxt = ST_NOVICTIM;
              fr_nxt = '0;
              vp_nxt = '0;
              state_nxt = S_OUT;
            end
            pass_nxt = 1'b1;
          end
        end
      end
      S_EVICT: begin
        ctl.op = OP_PTCLR;
        st_nxt = ST_REPLACE;
        fr_nxt = res_frame;
        vp_nxt = res_vpage;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (st_r == ST_REPLACE) ctl.op = OP_PLACE;
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r <= pass_nxt;
      ov_r <= ov_nxt;
    end
    st_r <= st_nxt;
    fr_r <= fr_nxt;
    vp_r <= vp_nxt;
  end
endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// testbench for second_chance_page_replacement: directed and random page requests
// checked against an in-bench model of the clock replacement policy
// depends on scpr_pkg, scpr_if and the block under test
module tb;
  import scpr_pkg::*;

  localparam int NFR = FRAMES_DEF;
  localparam int NPG = OWNERS_DEF * PAGES_PER_OWNER_DEF;
  localparam int IN_W = CMD_W + OWNER_W + PIDX_W;
  localparam int OUT_W = STATUS_W + FRAME_W + VPAGE_W;
  localparam int N_RANDOM = 2000;
  localparam int CALM_TAIL = 200;

  typedef struct packed {
    logic               cmd;
    logic [OWNER_W-1:0] owner;
    logic [PIDX_W-1:0]  pidx;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic [FRAME_W-1:0] frame;
    logic [VPAGE_W-1:0] victim;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors = 0;

  scpr_if #(IN_W)  in_ch (clk);
  scpr_if #(OUT_W) out_ch (clk);

  second_chance_page_replacement u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // mirror of frame table and page table
  logic               fr_valid [NFR];
  logic               fr_ref [NFR];
  logic [VPAGE_W-1:0] fr_page [NFR];
  logic [OWNER_W-1:0] fr_owner [NFR];
  logic               pg_present [NPG];
  logic [FRAME_W-1:0] pg_frame [NPG];

  request_t pending_reqs[$];
  answer_t  expected_answers[$];

  function automatic void install_page(int f, int gid, logic [OWNER_W-1:0] own);
    fr_valid[f] = 1'b1;
    fr_ref[f] = 1'b1;
    fr_page[f] = VPAGE_W'(gid);
    fr_owner[f] = own;
    pg_present[gid] = 1'b1;
    pg_frame[gid] = FRAME_W'(f);
  endfunction

  // apply one request to the mirror and queue the answer it must produce
  function automatic void predict_answer(request_t r);
    answer_t a;
    int gid;
    int f;
    bit done;
    a = '{ST_NOVICTIM, '0, '0};
    gid = r.owner * PAGES_PER_OWNER_DEF + r.pidx;
    done = 1'b0;
    if (r.cmd == CMD_RELEASE) begin
      if (pg_present[gid]) begin
        f = pg_frame[gid];
        fr_valid[f] = 1'b0;
        fr_ref[f] = 1'b0;
        pg_present[gid] = 1'b0;
        a = '{ST_RELEASED, FRAME_W'(f), '0};
      end else begin
        a = '{ST_ABSENT, '0, '0};
      end
    end else if (pg_present[gid]) begin
      f = pg_frame[gid];
      fr_ref[f] = 1'b1;
      a = '{ST_HIT, FRAME_W'(f), '0};
    end else begin
      // lowest free frame first
      for (f = 0; f < NFR && !done; f++) begin
        if (!fr_valid[f]) begin
          install_page(f, gid, r.owner);
          a = '{ST_FILL, FRAME_W'(f), '0};
          done = 1'b1;
        end
      end
      // second chance sweep, two passes, skipping the requester's frames
      for (int p = 0; p < 2 && !done; p++) begin
        for (f = 0; f < NFR && !done; f++) begin
          if (fr_owner[f] != r.owner) begin
            if (fr_ref[f]) begin
              fr_ref[f] = 1'b0;
            end else begin
              a = '{ST_REPLACE, FRAME_W'(f), fr_page[f]};
              pg_present[fr_page[f]] = 1'b0;
              install_page(f, gid, r.owner);
              done = 1'b1;
            end
          end
        end
      end
    end
    expected_answers.push_back(a);
  endfunction

  // driver: feeds pending requests with random idle bursts
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
        in_gap <= $urandom_range(0, 2);
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        request_t r;
        r = pending_reqs.pop_front();
        predict_answer(r);
        in_ch.valid <= 1'b1;
        in_ch.data <= r;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: random stalls on the result side, compares each transaction
  int out_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        answer_t got;
        answer_t want;
        got = out_ch.data;
        if (expected_answers.size() == 0) begin
          $error("unexpected result transaction %h", out_ch.data);
          errors++;
        end else begin
          want = expected_answers.pop_front();
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
          end
          if (got.frame !== want.frame) begin
            $error("frame expected %0d actual %0d", want.frame, got.frame);
            errors++;
          end
          if (got.victim !== want.victim) begin
            $error("victim_page expected %0d actual %0d", want.victim, got.victim);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
        out_gap <= $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic request_t mk_req(logic c, int own, int pi);
    request_t r;
    r.cmd = c;
    r.owner = OWNER_W'(own);
    r.pidx = PIDX_W'(pi);
    return r;
  endfunction

  // stimulus and end of run
  initial begin
    for (int i = 0; i < NFR; i++) begin
      fr_valid[i] = 1'b0;
      fr_ref[i] = 1'b0;
      fr_page[i] = '0;
      fr_owner[i] = '0;
    end
    for (int i = 0; i < NPG; i++) begin
      pg_present[i] = 1'b0;
      pg_frame[i] = '0;
    end

    // directed: fill, hit, release, release of absent page, field extremes
    pending_reqs.push_back(mk_req(CMD_ACCESS, 15, 15));
    pending_reqs.push_back(mk_req(CMD_ACCESS, 15, 15));
    pending_reqs.push_back(mk_req(CMD_RELEASE, 15, 15));
    pending_reqs.push_back(mk_req(CMD_RELEASE, 15, 15));
    pending_reqs.push_back(mk_req(CMD_ACCESS, 0, 0));
    pending_reqs.push_back(mk_req(CMD_RELEASE, 0, 0));
    pending_reqs.push_back(mk_req(CMD_RELEASE, 0, 0));
    pending_reqs.push_back(mk_req(CMD_ACCESS, 10, 5));
    pending_reqs.push_back(mk_req(CMD_ACCESS, 5, 10));
    pending_reqs.push_back(mk_req(CMD_ACCESS, 10, 5));

    // random: mostly accesses so the pool fills and the sweep runs often
    for (int i = 0; i < N_RANDOM; i++) begin
      pending_reqs.push_back(mk_req($urandom_range(0, 4) == 0 ? CMD_RELEASE : CMD_ACCESS,
                                    $urandom_range(0, 15), $urandom_range(0, 15)));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_reqs.size() == 0 && expected_answers.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("tb failed");
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/scpr_pkg.sv
hdl/scpr_if.sv
hdl/scpr_datapath.sv
hdl/scpr_ctrl.sv
hdl/second_chance_page_replacement.sv
test/tb.sv
